### hdl/tsd_pkg.sv
// ----------------------------------------------------------------------------
// tsd_pkg: shared types and constants of the timestamp string decoder
// Holds the byte token passed from the front to the back, the error codes
// and the per-field range limits.
// ----------------------------------------------------------------------------
package tsd_pkg;

	localparam int NUM_FIELDS = 6;
	localparam logic [3:0] REC_LAST = 4'd14;
	localparam logic [3:0] YEAR_LEN = 4'd4;

	localparam logic [7:0] CH_WILD = 8'h3F;
	localparam logic [7:0] CH_NUL = 8'h00;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;

	localparam logic [2:0] ERR_NONE = 3'd0;
	localparam logic [2:0] ERR_TERM = 3'd1;
	localparam logic [2:0] ERR_YEAR = 3'd2;
	localparam logic [2:0] ERR_MONTH = 3'd3;
	localparam logic [2:0] ERR_DAY = 3'd4;
	localparam logic [2:0] ERR_HOUR = 3'd5;
	localparam logic [2:0] ERR_MINUTE = 3'd6;
	localparam logic [2:0] ERR_SECOND = 3'd7;

	localparam logic [2:0] FIELD_ERR [NUM_FIELDS] = '{
		ERR_YEAR, ERR_MONTH, ERR_DAY, ERR_HOUR, ERR_MINUTE, ERR_SECOND
	};
	localparam logic [13:0] LIM_LOW [NUM_FIELDS] = '{
		14'd1, 14'd1, 14'd1, 14'd0, 14'd0, 14'd0
	};
	localparam logic [13:0] LIM_HIGH [NUM_FIELDS] = '{
		14'd9999, 14'd12, 14'd31, 14'd24, 14'd60, 14'd60
	};

	typedef enum logic [1:0] {
		KIND_DIGIT,
		KIND_NUL,
		KIND_BAD,
		KIND_WILD
	} tsd_kind_t;

	typedef struct packed {
		logic [2:0] field_idx;
		tsd_kind_t kind;
		logic [3:0] digit;
		logic last;
	} tsd_tok_t;

endpackage

### hdl/timestamp_string_decoder_unit.sv
// After the terminator byte is accepted, its token passes through the token queue,
// behind any tokens ahead of it, and is then decoded into the result register.
// Bytes are taken one per cycle while the token queue is not full; the field
// accumulator retires one token a cycle unless an earlier result still waits.
// Reset (arst_n low, asynchronous) clears the byte position, the token queue,
// the field lanes and the result valid; the first byte after reset is byte 0.
// ----------------------------------------------------------------------------
// timestamp_string_decoder_unit: YYYYMMDDhhmmss record decoder
// Takes a 15-byte timestamp record one byte per transaction and gives one
// result transaction with six decoded values, a wildcard mask and an error.
// ----------------------------------------------------------------------------
module timestamp_string_decoder_unit import tsd_pkg::*; #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic [7:0] ch,
	output logic out_valid,
	input  logic out_stall,
	output logic ok,
	output logic [2:0] err_code,
	output logic [5:0] wild_mask,
	output logic [13:0] year_out,
	output logic [6:0] month_out,
	output logic [6:0] day_out,
	output logic [6:0] hour_out,
	output logic [6:0] minute_out,
	output logic [6:0] second_out
);

	// The front classifies every accepted byte as soon as it arrives; it only
	// stalls when the token queue is full. The back drains the queue at one
	// token per cycle and holds only the terminator token while an earlier
	// result transaction still waits in the output register.
	logic in_accept;
	logic q_full;
	logic q_not_empty;
	logic q_pop;
	tsd_tok_t front_tok;
	tsd_tok_t back_tok;

	assign in_stall = q_full;
	assign in_accept = in_valid && !q_full;

	tsd_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.accept(in_accept),
		.ch(ch),
		.tok(front_tok)
	);

	tsd_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(in_accept),
		.push_tok(front_tok),
		.full(q_full),
		.pop(q_pop),
		.not_empty(q_not_empty),
		.pop_tok(back_tok)
	);

	// The back keeps one 14-bit accumulator per field and checks the ranges
	// in order of significance when the terminator arrives.
	tsd_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.tok_valid(q_not_empty),
		.tok(back_tok),
		.tok_pop(q_pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.ok(ok),
		.err_code(err_code),
		.wild_mask(wild_mask),
		.year_out(year_out),
		.month_out(month_out),
		.day_out(day_out),
		.hour_out(hour_out),
		.minute_out(minute_out),
		.second_out(second_out)
	);

	// The success flag always agrees with the error code.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (ok == (err_code == ERR_NONE)))
		else $error("ok flag disagrees with err_code");

	// A failed record shows no decoded values.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !ok) |-> (year_out == 14'd0 && month_out == 7'd0
			&& day_out == 7'd0 && hour_out == 7'd0 && minute_out == 7'd0
			&& second_out == 7'd0))
		else $error("failed record carries nonzero values");

	// A wildcard year, month or second reads as zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((!wild_mask[0] || year_out == 14'd0)
			&& (!wild_mask[1] || month_out == 7'd0)
			&& (!wild_mask[5] || second_out == 7'd0)))
		else $error("wildcard field carries a value");

	// A good record with no wildcard month has its month inside its limits.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && ok && !wild_mask[1]) |-> (month_out != 7'd0 && month_out <= 7'd12))
		else $error("accepted month out of range");

endmodule

### hdl/tsd_front.sv
// ----------------------------------------------------------------------------
// tsd_front: byte classifier
// Tracks the byte position within the record and turns each accepted byte
// into a token naming its field and its kind.
// ----------------------------------------------------------------------------
module tsd_front import tsd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic accept,
	input  logic [7:0] ch,
	output tsd_tok_t tok
);

	logic [3:0] position_q;
	logic [3:0] rel;
	logic starts;

	assign rel = position_q - YEAR_LEN;
	assign starts = (position_q == 4'd0) || ((position_q >= YEAR_LEN) && !rel[0]);

	always_comb begin
		tok.last = (position_q == REC_LAST);
		tok.digit = 4'(ch - CH_ZERO);
		tok.field_idx = (position_q < YEAR_LEN) ? 3'd0 : 3'(rel[3:1] + 3'd1);
		if (!tok.last && starts && ch == CH_WILD) begin
			tok.kind = KIND_WILD;
		end else if (ch == CH_NUL) begin
			tok.kind = KIND_NUL;
		end else if (!tok.last && ch >= CH_ZERO && ch <= CH_NINE) begin
			tok.kind = KIND_DIGIT;
		end else begin
			tok.kind = KIND_BAD;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			position_q <= 4'd0;
		end else if (accept) begin
			position_q <= (position_q == REC_LAST) ? 4'd0 : position_q + 4'd1;
		end
	end

endmodule

### hdl/tsd_queue.sv
// ----------------------------------------------------------------------------
// tsd_queue: token queue
// A small register FIFO between the classifier and the field accumulator.
// ----------------------------------------------------------------------------
module tsd_queue import tsd_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  tsd_tok_t push_tok,
	output logic full,
	input  logic pop,
	output logic not_empty,
	output tsd_tok_t pop_tok
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	tsd_tok_t slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full = (count_q == CNT_W'(DEPTH));
	assign not_empty = (count_q != '0);
	assign pop_tok = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_tok;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### hdl/tsd_back.sv
// ----------------------------------------------------------------------------
// tsd_back: field accumulator and result register
// Applies tokens to six per-field lanes and, on the terminator token, checks
// the fields and loads the result register.
// ----------------------------------------------------------------------------
module tsd_back import tsd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic tok_valid,
	input  tsd_tok_t tok,
	output logic tok_pop,
	output logic out_valid,
	input  logic out_stall,
	output logic ok,
	output logic [2:0] err_code,
	output logic [5:0] wild_mask,
	output logic [13:0] year_out,
	output logic [6:0] month_out,
	output logic [6:0] day_out,
	output logic [6:0] hour_out,
	output logic [6:0] minute_out,
	output logic [6:0] second_out
);

	logic [13:0] value_q [NUM_FIELDS];
	logic [NUM_FIELDS-1:0] bad_q;
	logic [NUM_FIELDS-1:0] ended_q;
	logic [NUM_FIELDS-1:0] wild_q;
	logic [2:0] err;
	logic [13:0] shown [NUM_FIELDS];

	// The terminator token may only leave the queue when the result register is free.
	assign tok_pop = tok_valid && (!tok.last || !out_valid || !out_stall);

	always_comb begin
		err = ERR_NONE;
		if (tok.kind != KIND_NUL) begin
			err = ERR_TERM;
		end else begin
			for (int j = NUM_FIELDS - 1; j >= 0; j--) begin
				if (!wild_q[j] && (bad_q[j] || value_q[j] < LIM_LOW[j]
						|| value_q[j] > LIM_HIGH[j])) begin
					err = FIELD_ERR[j];
				end
			end
		end
		for (int j = 0; j < NUM_FIELDS; j++) begin
			shown[j] = (err == ERR_NONE && !wild_q[j]) ? value_q[j] : 14'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bad_q <= '0;
			ended_q <= '0;
			wild_q <= '0;
			for (int j = 0; j < NUM_FIELDS; j++) begin
				value_q[j] <= 14'd0;
			end
		end else if (tok_pop) begin
			if (tok.last) begin
				bad_q <= '0;
				ended_q <= '0;
				wild_q <= '0;
				for (int j = 0; j < NUM_FIELDS; j++) begin
					value_q[j] <= 14'd0;
				end
			end else begin
				for (int j = 0; j < NUM_FIELDS; j++) begin
					if (tok.field_idx == 3'(j)) begin
						if (tok.kind == KIND_WILD) begin
							wild_q[j] <= 1'b1;
						end else if (!wild_q[j] && !ended_q[j]) begin
							case (tok.kind)
								KIND_NUL: begin
									ended_q[j] <= 1'b1;
								end
								KIND_DIGIT: begin
									value_q[j] <= 14'((value_q[j] << 3) + (value_q[j] << 1)
										+ 14'(tok.digit));
								end
								default: begin
									bad_q[j] <= 1'b1;
									ended_q[j] <= 1'b1;
								end
							endcase
						end
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (tok_pop && tok.last) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (tok_pop && tok.last) begin
			ok <= (err == ERR_NONE);
			err_code <= err;
			wild_mask <= wild_q;
			year_out <= shown[0];
			month_out <= shown[1][6:0];
			day_out <= shown[2][6:0];
			hour_out <= shown[3][6:0];
			minute_out <= shown[4][6:0];
			second_out <= shown[5][6:0];
		end
	end

endmodule

### verif/tb_timestamp_string_decoder_unit.sv
// ----------------------------------------------------------------------------
// tb_timestamp_string_decoder_unit: self-checking bench for the record decoder
// Streams 15-byte timestamp records into the decoder under several idling
// patterns, predicts every result from its own copy of the decoding rules and
// compares each result transaction field by field as it leaves the block.
// ----------------------------------------------------------------------------
module tb_timestamp_string_decoder_unit;
	import tsd_pkg::*;

	localparam int RECORD_LEN = 15;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int HOLD_CYCLES = 400;
	localparam int DRAIN_CYCLES = 8;
	localparam int MAX_PRINTED = 40;

	// Legal range of each field, year first. These are the decoder's lax limits:
	// hour may reach 24 and minute and second may reach 60.
	localparam int FIELD_MIN [6] = '{1, 1, 1, 0, 0, 0};
	localparam int FIELD_MAX [6] = '{9999, 12, 31, 24, 60, 60};
	localparam logic [2:0] RANGE_ERR [6] = '{
		ERR_YEAR, ERR_MONTH, ERR_DAY, ERR_HOUR, ERR_MINUTE, ERR_SECOND
	};

	// How the random generator fills one field of a record.
	typedef enum {
		SHAPE_GOOD,
		SHAPE_WILD,
		SHAPE_RANGE,
		SHAPE_SHORT,
		SHAPE_BAD
	} field_shape_t;

	// One decoded timestamp, as it leaves the block.
	typedef struct packed {
		logic ok;
		logic [2:0] err_code;
		logic [5:0] wild_mask;
		logic [13:0] year;
		logic [6:0] month;
		logic [6:0] day;
		logic [6:0] hour;
		logic [6:0] minute;
		logic [6:0] second;
	} stamp_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [7:0] ch = 8'h00;
	logic out_valid;
	logic out_stall = 1'b0;
	logic ok;
	logic [2:0] err_code;
	logic [5:0] wild_mask;
	logic [13:0] year_out;
	logic [6:0] month_out;
	logic [6:0] day_out;
	logic [6:0] hour_out;
	logic [6:0] minute_out;
	logic [6:0] second_out;

	// Bytes waiting to be offered, and decoded records waiting to come out.
	logic [7:0] byte_backlog [$];
	stamp_t expected_stamps [$];
	logic [7:0] draft [RECORD_LEN];

	// Idling knobs, in percent, changed by the sequence between phases.
	int send_idle_pct = 0;
	int stall_pct = 0;
	bit pressure_armed = 1'b0;
	int hold_count = 0;

	// Mirror of the decoder state.
	logic [3:0] next_pos = '0;
	logic [13:0] field_acc [6];
	bit field_bad [6];
	bit field_done [6];
	logic [5:0] wild_seen = '0;

	int failures = 0;
	int idle_cycles = 0;
	int records_seen = 0;
	int bytes_taken = 0;
	int clean_count = 0;
	int wild_fields = 0;
	int err_hits [8];

	timestamp_string_decoder_unit i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.ch(ch),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.ok(ok),
		.err_code(err_code),
		.wild_mask(wild_mask),
		.year_out(year_out),
		.month_out(month_out),
		.day_out(day_out),
		.hour_out(hour_out),
		.minute_out(minute_out),
		.second_out(second_out)
	);

	always #5 clk = ~clk;

	// ------------------------------------------------------------------
	// Prediction
	// ------------------------------------------------------------------

	// Return the mirror to its state after reset, as after every record.
	function automatic void clear_mirror();
		next_pos = '0;
		wild_seen = '0;
		for (int j = 0; j < 6; j++) begin
			field_acc[j] = '0;
			field_bad[j] = 1'b0;
			field_done[j] = 1'b0;
		end
	endfunction

	// The year takes bytes 0 to 3; the other fields take two bytes each.
	function automatic int field_at(input logic [3:0] p);
		return (p < 4) ? 0 : ((p - 4) >> 1) + 1;
	endfunction

	function automatic bit opens_field(input logic [3:0] p);
		return p == 0 || (p >= 4 && p[0] == 1'b0);
	endfunction

	// Fold one accepted byte into the mirror. The fifteenth byte closes the
	// record and leaves one expected result in the store.
	function automatic void decode_byte(input logic [7:0] c);
		int f;
		logic [2:0] err;
		stamp_t want;
		if (next_pos < REC_LAST) begin
			f = field_at(next_pos);
			// A question mark only counts as a wildcard in the first byte of its field.
			if (opens_field(next_pos) && c == CH_WILD)
				wild_seen[f] = 1'b1;
			if (!wild_seen[f] && !field_done[f]) begin
				if (c == CH_NUL) begin
					field_done[f] = 1'b1;
				end else if (c >= CH_ZERO && c <= CH_NINE) begin
					field_acc[f] = 14'(field_acc[f] * 10 + (c - CH_ZERO));
				end else begin
					field_bad[f] = 1'b1;
					field_done[f] = 1'b1;
				end
			end
			next_pos = next_pos + 4'd1;
			return;
		end
		// The terminator is judged first, then the fields in order; the first
		// failure wins and wildcard fields are never judged.
		err = ERR_NONE;
		if (c != CH_NUL) begin
			err = ERR_TERM;
		end else begin
			for (int j = 0; j < 6; j++) begin
				if (err == ERR_NONE && !wild_seen[j] && (field_bad[j]
						|| field_acc[j] < FIELD_MIN[j] || field_acc[j] > FIELD_MAX[j]))
					err = RANGE_ERR[j];
			end
		end
		want = '0;
		want.ok = (err == ERR_NONE);
		want.err_code = err;
		want.wild_mask = wild_seen;
		// A rejected record gives all six values as zero, as do wildcard fields.
		if (err == ERR_NONE) begin
			want.year = wild_seen[0] ? '0 : field_acc[0];
			want.month = wild_seen[1] ? '0 : field_acc[1][6:0];
			want.day = wild_seen[2] ? '0 : field_acc[2][6:0];
			want.hour = wild_seen[3] ? '0 : field_acc[3][6:0];
			want.minute = wild_seen[4] ? '0 : field_acc[4][6:0];
			want.second = wild_seen[5] ? '0 : field_acc[5][6:0];
		end
		expected_stamps.push_back(want);
		clear_mirror();
	endfunction

	// ------------------------------------------------------------------
	// Checking
	// ------------------------------------------------------------------

	// Print one line per failure, up to a cap, and count all of them.
	task automatic report_failure(input string msg);
		failures++;
		if (failures <= MAX_PRINTED)
			$display("%0t: mismatch: %s", $realtime, msg);
	endtask

	task automatic check_field(input string name, input logic [13:0] got,
			input logic [13:0] want);
		if (got !== want)
			report_failure($sformatf("record %0d %s is %0d, expected %0d",
				records_seen, name, got, want));
	endtask

	// Monitor and watchdog. Everything is sampled at the rising edge, where the
	// values seen are those that were settled before the edge.
	always @(posedge clk) begin
		stamp_t want;
		bit moved;
		moved = 1'b0;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				decode_byte(ch);
				bytes_taken++;
				moved = 1'b1;
			end
			if (out_valid && !out_stall) begin
				moved = 1'b1;
				if (expected_stamps.size() == 0) begin
					report_failure("result transaction with no record pending");
				end else begin
					want = expected_stamps.pop_front();
					check_field("ok", 14'(ok), 14'(want.ok));
					check_field("err_code", 14'(err_code), 14'(want.err_code));
					check_field("wild_mask", 14'(wild_mask), 14'(want.wild_mask));
					check_field("year_out", year_out, want.year);
					check_field("month_out", 14'(month_out), 14'(want.month));
					check_field("day_out", 14'(day_out), 14'(want.day));
					check_field("hour_out", 14'(hour_out), 14'(want.hour));
					check_field("minute_out", 14'(minute_out), 14'(want.minute));
					check_field("second_out", 14'(second_out), 14'(want.second));
					records_seen++;
					if (want.ok)
						clean_count++;
					err_hits[want.err_code]++;
					wild_fields += $countones(want.wild_mask);
				end
			end
			idle_cycles <= moved ? 0 : idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("Watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
				$display("tb_timestamp_string_decoder_unit: FAIL");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// Driver and receiver
	// ------------------------------------------------------------------

	// The sender offers the next byte once the current one is taken, or idles at
	// random. A stalled byte is held as it is.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || !in_stall) begin
			if (byte_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				in_valid <= 1'b1;
				ch <= byte_backlog.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// The receiver stalls at random. Once pressure is armed it holds off for a
	// long stretch first, so that the decoder backs up into its input.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else if (pressure_armed && hold_count < HOLD_CYCLES) begin
			out_stall <= 1'b1;
			hold_count <= hold_count + 1;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------

	task automatic commit_draft();
		for (int i = 0; i < RECORD_LEN; i++)
			byte_backlog.push_back(draft[i]);
	endtask

	// Queue a hand-written record. A dot in the text stands for a NUL byte.
	task automatic queue_text(input string text, input logic [7:0] term);
		for (int i = 0; i < RECORD_LEN - 1; i++)
			draft[i] = (text[i] == ".") ? CH_NUL : text[i];
		draft[RECORD_LEN - 1] = term;
		commit_draft();
	endtask

	task automatic put_digits(input int first, input int len, input int value);
		for (int i = len - 1; i >= 0; i--) begin
			draft[first + i] = 8'(CH_ZERO + value % 10);
			value = value / 10;
		end
	endtask

	// Fill one field of the draft record in the chosen shape.
	task automatic draw_field(input int f, input bit clean);
		int first;
		int len;
		int value;
		int k;
		logic [7:0] odd;
		field_shape_t shape;
		first = (f == 0) ? 0 : 4 + 2 * (f - 1);
		len = (f == 0) ? 4 : 2;
		if (clean)
			shape = ($urandom_range(99) < 15) ? SHAPE_WILD : SHAPE_GOOD;
		else
			shape = field_shape_t'($urandom_range(4));
		for (int i = 0; i < len; i++)
			draft[first + i] = 8'($urandom_range(255));
		k = $urandom_range(len - 1);
		case (shape)
			SHAPE_GOOD: begin
				// Bias toward the ends of the legal range.
				case ($urandom_range(9))
					0: value = FIELD_MIN[f];
					1: value = FIELD_MAX[f];
					default: value = $urandom_range(FIELD_MAX[f], FIELD_MIN[f]);
				endcase
				put_digits(first, len, value);
			end
			SHAPE_WILD: begin
				// Whatever follows the question mark must be ignored.
				draft[first] = CH_WILD;
			end
			SHAPE_RANGE: begin
				// Four digits cannot exceed the year limit, so a bad year is zero.
				if (f == 0 || (f < 3 && $urandom_range(1)))
					value = 0;
				else
					value = $urandom_range(99, FIELD_MAX[f] + 1);
				put_digits(first, len, value);
			end
			SHAPE_SHORT: begin
				// Digits, then a NUL that ends the field early; an empty field
				// when the NUL comes first. The bytes after it stay random.
				for (int i = 0; i < k; i++)
					draft[first + i] = 8'(CH_ZERO + $urandom_range(9));
				draft[first + k] = CH_NUL;
			end
			default: begin
				// Spaces and signs, which a lenient parser would skip, and other
				// non-digits spoil the field, but a question mark as its first byte makes a wildcard.
				case ($urandom_range(3))
					0: odd = " ";
					1: odd = "+";
					2: odd = "-";
					default: begin
						do
							odd = 8'($urandom_range(255, 1));
						while (odd >= CH_ZERO && odd <= CH_NINE);
					end
				endcase
				for (int i = 0; i < k; i++)
					draft[first + i] = 8'(CH_ZERO + $urandom_range(9));
				draft[first + k] = odd;
			end
		endcase
	endtask

	// Nine records in ten are drawn field by field, half from good and wildcard
	// shapes only and half from every shape; the rest are plain noise.
	task automatic queue_random_record();
		bit clean;
		if ($urandom_range(9) == 0) begin
			for (int i = 0; i < RECORD_LEN; i++)
				draft[i] = 8'($urandom_range(255));
			if ($urandom_range(1))
				draft[RECORD_LEN - 1] = CH_NUL;
		end else begin
			clean = 1'($urandom_range(1));
			for (int f = 0; f < 6; f++)
				draw_field(f, clean);
			draft[RECORD_LEN - 1] = ($urandom_range(99) < 7) ? 8'($urandom_range(255, 1))
				: CH_NUL;
		end
		commit_draft();
	endtask

	// Wait until every byte has been taken and every expected result has come.
	task automatic wait_drained();
		while (byte_backlog.size() != 0 || in_valid || expected_stamps.size() != 0)
			@(posedge clk);
	endtask

	task automatic run_phase(input int records, input int idle, input int stall);
		send_idle_pct = idle;
		stall_pct = stall;
		for (int r = 0; r < records; r++)
			queue_random_record();
		wait_drained();
	endtask

	initial begin
		clear_mirror();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed records: both ends of every range, all wildcards with junk
		// behind them, a bad terminator, a zero year, early NULs and empty
		// fields, non-digits at the start and inside a field, and a month of 13.
		queue_text("99991231246060", CH_NUL);
		queue_text("00010101000000", CH_NUL);
		queue_text("?xyz?a?b?c?d?e", CH_NUL);
		queue_text("20240615123045", 8'hFF);
		queue_text("00000101000000", CH_NUL);
		queue_text("7.zz1.9...5..?", CH_NUL);
		queue_text(" 024010100000.", CH_NUL);
		queue_text("2?2401010000.0", CH_NUL);
		queue_text("20241301000000", CH_NUL);
		wait_drained();

		run_phase(20, 0, 0);
		run_phase(20, 46, 0);
		run_phase(20, 0, 46);
		run_phase(20, 23, 23);

		// Pressure: the receiver holds off while the sender keeps offering.
		pressure_armed = 1'b1;
		run_phase(8, 0, 10);

		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Covered %0d records (%0d bytes): %0d decoded, %0d rejected, %0d wildcard fields.",
			records_seen, bytes_taken, clean_count, records_seen - clean_count, wild_fields);
		$display("Errors by code: term %0d year %0d month %0d day %0d hour %0d min %0d sec %0d.",
			err_hits[ERR_TERM], err_hits[ERR_YEAR], err_hits[ERR_MONTH], err_hits[ERR_DAY],
			err_hits[ERR_HOUR], err_hits[ERR_MINUTE], err_hits[ERR_SECOND]);
		if (failures == 0 && expected_stamps.size() == 0) begin
			$display("tb_timestamp_string_decoder_unit: PASS");
		end else begin
			$display("tb_timestamp_string_decoder_unit: FAIL");
		end
		$finish;
	end

endmodule
